FILE: rtl/xsmm_pkg.sv
// Package with the shared constants of the xor-structured matrix multiply block.
package xsmm_pkg;

	localparam int MAX_SIZE_DEF   = 64;
	localparam int VALUE_BITS_DEF = 16;

	localparam int SIZE_BITS    = 3;
	localparam int PRODUCT_BITS = 41;
	localparam int POS_BITS     = 6;
	localparam int OUT_BITS     = ((PRODUCT_BITS + POS_BITS + 7) / 8) * 8;

	localparam logic [SIZE_BITS-1:0] SIZE_RESET = 3'd6;

endpackage

FILE: rtl/xsmm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module xsmm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/xor_structured_matrix_multiply_top.sv
// Top level of the xor-structured matrix multiply block (xor convolution of first rows).
//
//   channel   direction  beat content
//   s_axis    in         one pair of first-row values a, b
//   m_axis    out        one element of the product's first row, tlast on the final one
//   cfg       in         size_log2 of the matrix in use
//
// Loading takes one beat per cycle. After the N-th beat one shared multiplier and
// accumulator work through c[k] = sum a[i]*b[i^k] one element at a time: N reads of
// the two stores pass the read and product registers into the accumulator, and the
// sum is registered for the output handshake. Reset clears the control state, the
// accumulator and the output registers, not the stores or the product register. The
// block takes no beat while computing; a stalled output holds it.
module xor_structured_matrix_multiply_top
	import xsmm_pkg::*;
#(
	parameter int MAX_SIZE   = MAX_SIZE_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	// a_value, b_value from the lowest bit up, zero filled to whole bytes
	input  logic [((2*VALUE_BITS+7)/8)*8-1:0]       s_axis_tdata,
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	// product_value, position from the lowest bit up, zero filled to whole bytes
	output logic [OUT_BITS-1:0]                     m_axis_tdata,
	output logic                                    m_axis_tlast,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [SIZE_BITS-1:0]                    cfg_data
);

	localparam int LOG_MAX = $clog2(MAX_SIZE + 1) - 1;
	localparam int ADDR_W  = (LOG_MAX < 1) ? 1 : LOG_MAX;
	localparam int CNT_W   = ADDR_W + 1;
	localparam int PROD_W  = 2 * VALUE_BITS;

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	logic [1:0]                    state_q;
	logic [SIZE_BITS-1:0]          size_q;
	logic [CNT_W-1:0]              load_cnt_q;
	logic [CNT_W-1:0]              n_q;
	logic [ADDR_W-1:0]             k_q;
	logic [ADDR_W-1:0]             i_q;
	logic signed [PRODUCT_BITS-1:0] acc_q;
	logic [PRODUCT_BITS-1:0]       out_value_q;
	logic [ADDR_W-1:0]             out_pos_q;
	logic                          out_last_q;
	logic                          out_valid_q;

	logic                          v_s1;
	logic                          last_s1;
	logic                          v_s2;
	logic                          last_s2;
	logic signed [PROD_W-1:0]      prod_s2;

	logic [SIZE_BITS-1:0]          eff_lg;
	logic [CNT_W-1:0]              n_eff;
	logic [CNT_W-1:0]              cnt_next;
	logic                          in_beat;
	logic                          issue;
	logic                          issue_last;
	logic [VALUE_BITS-1:0]         a_rd;
	logic [VALUE_BITS-1:0]         b_rd;
	logic signed [PRODUCT_BITS-1:0] prod_ext;
	logic signed [PRODUCT_BITS-1:0] acc_sum;
	logic                          k_last;

	assign eff_lg     = (size_q > SIZE_BITS'(LOG_MAX)) ? SIZE_BITS'(LOG_MAX) : size_q;
	assign n_eff      = CNT_W'(1) << eff_lg;
	assign cnt_next   = load_cnt_q + CNT_W'(1);
	assign in_beat    = s_axis_tvalid && s_axis_tready;
	assign issue      = (state_q == ST_ISSUE);
	assign issue_last = ({1'b0, i_q} == CNT_W'(n_q - CNT_W'(1)));
	assign k_last     = ({1'b0, k_q} == CNT_W'(n_q - CNT_W'(1)));
	assign prod_ext   = PRODUCT_BITS'(prod_s2);
	assign acc_sum    = acc_q + prod_ext;

	assign s_axis_tready = (state_q == ST_LOAD);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = OUT_BITS'({POS_BITS'(out_pos_q), out_value_q});

	xsmm_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(1 << ADDR_W)
	) u_a_ram (
		.clk    (clk),
		.wr_en  (in_beat),
		.wr_addr(load_cnt_q[ADDR_W-1:0]),
		.wr_data(s_axis_tdata[VALUE_BITS-1:0]),
		.rd_en  (issue),
		.rd_addr(i_q),
		.rd_data(a_rd)
	);

	xsmm_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(1 << ADDR_W)
	) u_b_ram (
		.clk    (clk),
		.wr_en  (in_beat),
		.wr_addr(load_cnt_q[ADDR_W-1:0]),
		.wr_data(s_axis_tdata[2*VALUE_BITS-1:VALUE_BITS]),
		.rd_en  (issue),
		.rd_addr(i_q ^ k_q),
		.rd_data(b_rd)
	);

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(a_rd) * $signed(b_rd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			size_q      <= SIZE_RESET;
			load_cnt_q  <= '0;
			n_q         <= '0;
			k_q         <= '0;
			i_q         <= '0;
			acc_q       <= '0;
			out_value_q <= '0;
			out_pos_q   <= '0;
			out_last_q  <= 1'b0;
			out_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			last_s1     <= 1'b0;
			v_s2        <= 1'b0;
			last_s2     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				size_q <= cfg_data;
			end

			v_s1    <= issue;
			last_s1 <= issue && issue_last;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			if (v_s2) begin
				acc_q <= acc_sum;
			end

			unique case (state_q)
				ST_LOAD: begin
					if (in_beat) begin
						if (cnt_next >= n_eff) begin
							load_cnt_q <= '0;
							n_q        <= n_eff;
							k_q        <= '0;
							i_q        <= '0;
							acc_q      <= '0;
							state_q    <= ST_ISSUE;
						end else begin
							load_cnt_q <= cnt_next;
						end
					end
				end
				ST_ISSUE: begin
					i_q <= i_q + ADDR_W'(1);
					if (issue_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (v_s2 && last_s2) begin
						out_value_q <= acc_sum;
						out_pos_q   <= k_q;
						out_last_q  <= k_last;
						out_valid_q <= 1'b1;
						state_q     <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_axis_tready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							state_q <= ST_LOAD;
						end else begin
							k_q     <= k_q + ADDR_W'(1);
							i_q     <= '0;
							acc_q   <= '0;
							state_q <= ST_ISSUE;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

FILE: verif/xsmm_checker.sv
// Checker for the xor-structured matrix multiply block: predicts each product row and compares the output beats.
module xsmm_checker
	import xsmm_pkg::*;
(
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	input  logic                                 s_axis_tready,
	// a_value, b_value from the lowest bit up
	input  logic [((2*VALUE_BITS_DEF+7)/8)*8-1:0] s_axis_tdata,
	input  logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// product_value, position from the lowest bit up, zero filled
	input  logic [OUT_BITS-1:0]                  m_axis_tdata,
	input  logic                                 m_axis_tlast,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [SIZE_BITS-1:0]                 cfg_data,
	output int                                   mismatch_count,
	output int                                   pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROW_DEPTH = MAX_SIZE_DEF;
	localparam int MAX_LOG2  = $clog2(MAX_SIZE_DEF);
	localparam int COUNT_WRAP = 2 * MAX_SIZE_DEF;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic signed [PRODUCT_BITS-1:0] value;
		logic [POS_BITS-1:0]            position;
		logic                           last;
	} row_elem_t;

	logic [SIZE_BITS-1:0]             size_log2 = SIZE_RESET;
	logic signed [VALUE_BITS_DEF-1:0] a_row [ROW_DEPTH];
	logic signed [VALUE_BITS_DEF-1:0] b_row [ROW_DEPTH];
	int unsigned                      pairs_loaded = 0;
	row_elem_t                        expected_row [$];

	initial begin
		mismatch_count = 0;
		pending_count  = 0;
	end

	// Sizes beyond the largest supported one are clamped to it.
	function automatic int unsigned row_length(input logic [SIZE_BITS-1:0] lg);
		return 1 << ((lg > MAX_LOG2) ? MAX_LOG2 : lg);
	endfunction

	function automatic void predict_product_row(input int unsigned n);
		logic signed [PRODUCT_BITS-1:0] acc;
		row_elem_t                      elem;
		int unsigned                    k;
		int unsigned                    i;
		for (k = 0; k < n; k++) begin
			acc = '0;
			for (i = 0; i < n; i++)
				acc += a_row[i] * b_row[i ^ k];
			elem.value    = acc;
			elem.position = k[POS_BITS-1:0];
			elem.last     = (k + 1 == n);
			expected_row.push_back(elem);
		end
	endfunction

	function automatic void flag_mismatch(input string what, input longint want,
			input longint got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("[%0t] %s mismatch: expected %0d, got %0d", $time, what, want, got);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		row_elem_t                      want;
		logic signed [PRODUCT_BITS-1:0] got_value;
		logic [POS_BITS-1:0]            got_position;
		if (!arst_n) begin
			size_log2    = SIZE_RESET;
			pairs_loaded = 0;
			expected_row.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_value    = m_axis_tdata[PRODUCT_BITS-1:0];
				got_position = m_axis_tdata[PRODUCT_BITS +: POS_BITS];
				if (expected_row.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("[%0t] Unexpected beat: value %0d, position %0d, last %0b",
							$time, got_value, got_position, m_axis_tlast);
				end else begin
					want = expected_row.pop_front();
					if (got_value !== want.value)
						flag_mismatch("Product value", want.value, got_value);
					if (got_position !== want.position)
						flag_mismatch("Position", want.position, got_position);
					if (m_axis_tlast !== want.last)
						flag_mismatch("Last flag", want.last, m_axis_tlast);
				end
			end
			if (cfg_valid && cfg_ready)
				size_log2 = cfg_data;
			if (s_axis_tvalid && s_axis_tready) begin
				a_row[pairs_loaded % ROW_DEPTH] = s_axis_tdata[VALUE_BITS_DEF-1:0];
				b_row[pairs_loaded % ROW_DEPTH] = s_axis_tdata[VALUE_BITS_DEF +: VALUE_BITS_DEF];
				pairs_loaded = (pairs_loaded + 1) % COUNT_WRAP;
				// A shrunken size may already be covered by the pairs held, so the run
				// closes on this beat and uses only the first pairs of the store.
				if (pairs_loaded >= row_length(size_log2)) begin
					predict_product_row(row_length(size_log2));
					pairs_loaded = 0;
				end
			end
		end
		pending_count = expected_row.size();
	end

endmodule

FILE: verif/tb.sv
// Testbench top for the xor-structured matrix multiply block: clock, reset, stimulus and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import xsmm_pkg::*;

	localparam realtime HALF_PERIOD   = 4.0;
	localparam int      RESET_CYCLES  = 5;
	localparam int      RANDOM_PAIRS  = 180;
	localparam int      SETTLE_CYCLES = 16;
	localparam int      TAIL_CYCLES   = 64;
	localparam int      WATCHDOG_LIMIT = 50000;
	localparam int      IN_BITS       = ((2*VALUE_BITS_DEF+7)/8)*8;

	localparam logic [VALUE_BITS_DEF-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS_DEF-1){1'b1}}};
	localparam logic [VALUE_BITS_DEF-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS_DEF-1){1'b0}}};
	localparam logic [VALUE_BITS_DEF-1:0] VALUE_ZERO = '0;
	localparam logic [VALUE_BITS_DEF-1:0] VALUE_MINUS_ONE = '1;

	localparam logic [SIZE_BITS-1:0] SIZE_ONE       = 3'd0;
	localparam logic [SIZE_BITS-1:0] SIZE_TWO       = 3'd1;
	localparam logic [SIZE_BITS-1:0] SIZE_FOUR      = 3'd2;
	localparam logic [SIZE_BITS-1:0] SIZE_EIGHT     = 3'd3;
	localparam logic [SIZE_BITS-1:0] SIZE_LARGEST   = 3'd6;
	localparam logic [SIZE_BITS-1:0] SIZE_OVERSIZED = 3'd7;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [IN_BITS-1:0]   s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OUT_BITS-1:0]  m_axis_tdata;
	logic                 m_axis_tlast;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [SIZE_BITS-1:0] cfg_data;

	int        mismatch_count;
	int        pending_count;
	int        quiet_cycles = 0;
	int        burst_left = 0;
	bit        bursty = 1'b1;
	int        pairs_sent = 0;
	logic [15:0] stall_pattern = 16'hFFFF;
	int        pattern_left = 0;

	always #(HALF_PERIOD) clk = ~clk;

	xor_structured_matrix_multiply_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	xsmm_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tlast   (m_axis_tlast),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	// The receiver replays a rotating ready pattern, reloaded each time pattern_left runs out.
	always @(negedge clk) begin
		if (pattern_left == 0) begin
			pattern_left  = 64;
			stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
		end
		m_axis_tready <= stall_pattern[0];
		stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
		pattern_left--;
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [VALUE_BITS_DEF-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return VALUE_MAX;
			1: return VALUE_MIN;
			2: return VALUE_BITS_DEF'($urandom_range(0, 7)) - VALUE_BITS_DEF'(4);
			default: return VALUE_BITS_DEF'($urandom());
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_pair(input logic [VALUE_BITS_DEF-1:0] a_value,
			input logic [VALUE_BITS_DEF-1:0] b_value);
		int gap;
		if (burst_left == 0) begin
			gap        = bursty ? $urandom_range(1, 6) : 0;
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				s_axis_tdata  <= IN_BITS'($urandom());
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b_value, a_value};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pairs_sent++;
		@(negedge clk);
	endtask

	// The size is only changed once every expected element has come out.
	task automatic write_size(input logic [SIZE_BITS-1:0] size_log2);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_count != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= size_log2;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [SIZE_BITS-1:0] lg;
		int unsigned          n;
		int unsigned          runs;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		bursty = 1'b0;
		write_size(SIZE_ONE);
		send_pair(VALUE_MAX, VALUE_MAX);
		send_pair(VALUE_MIN, VALUE_MIN);
		send_pair(VALUE_MIN, VALUE_MAX);
		send_pair(VALUE_ZERO, VALUE_ZERO);

		bursty = 1'b1;
		write_size(SIZE_TWO);
		send_pair(VALUE_MIN, VALUE_MIN);
		send_pair(VALUE_MAX, VALUE_MINUS_ONE);

		// Shrinking the size part way through a load, with more pairs held than needed.
		write_size(SIZE_EIGHT);
		repeat (5) send_pair(pick_value(), pick_value());
		write_size(SIZE_FOUR);
		send_pair(pick_value(), pick_value());

		// Shrinking part way through a load, with fewer pairs held than needed.
		write_size(SIZE_EIGHT);
		repeat (2) send_pair(pick_value(), pick_value());
		write_size(SIZE_FOUR);
		repeat (2) send_pair(pick_value(), pick_value());

		write_size(SIZE_LARGEST);
		repeat (8) send_pair(pick_value(), pick_value());
		write_size(SIZE_EIGHT);
		send_pair(pick_value(), pick_value());

		// An oversized setting is clamped to the largest matrix.
		write_size(SIZE_OVERSIZED);
		repeat (MAX_SIZE_DEF) send_pair(pick_value(), pick_value());

		while (pairs_sent < RANDOM_PAIRS) begin
			lg     = SIZE_BITS'($urandom_range(0, 5));
			n      = 1 << lg;
			runs   = (lg >= 4) ? 1 : $urandom_range(1, 3);
			bursty = ($urandom_range(0, 3) != 0);
			write_size(lg);
			repeat (runs * n) send_pair(pick_value(), pick_value());
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, n)) send_pair(pick_value(), pick_value());
		end

		s_axis_tvalid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && pending_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
